[rtl/core/sfd_pkg.sv]
// sfd_pkg: shared types and constants of the stereo feedback delay core.
// Register indexes, register widths and reset values. No dependencies.
`default_nettype none

package sfd_pkg;

  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 15;
  localparam int LEN_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_DRY_GAIN      = 2'd2,
    REG_WET_GAIN      = 2'd3
  } cfg_reg_e;

  localparam len_t  LEN_RST = 17'd65536;
  localparam gain_t FB_RST  = 16'd24576;
  localparam gain_t DRY_RST = 16'd32768;
  localparam gain_t WET_RST = 16'd24576;

endpackage

`default_nettype wire

[rtl/core/sfd_in_if.sv]
// sfd_in_if: valid/ready channel carrying one stereo input frame.
// Standalone, used by stereo_feedback_delay_core.
`default_nettype none

interface sfd_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_in;
  logic signed [W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

[rtl/core/sfd_out_if.sv]
// sfd_out_if: valid/ready channel carrying one stereo output frame.
// Standalone, used by stereo_feedback_delay_core.
`default_nettype none

interface sfd_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_out;
  logic signed [W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

[rtl/core/stereo_feedback_delay_core.sv]
// Stereo feedback echo delay. One frame is taken per cycle while the delay length is three
// frames or more and the output channel is not stalled; a frame passes the s1 and s2 stage
// registers into the output register. The rate is set by the read-modify-write loop on the
// single delay memory (one read port at transfer, one write port as the frame leaves s2):
// an input that addresses the same entry as a frame still in flight waits, so a length of
// two or one makes inputs wait for the write-back. Delay memory reads as zero after reset
// without a clearing pass: a fill count marks the prefix of entries ever written, so the
// block takes frames right out of reset. Depends on sfd_pkg, sfd_in_if and sfd_out_if.
`default_nettype none

module stereo_feedback_delay_core
  import sfd_pkg::*;
#(
  parameter int MAX_FRAMES  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  sfd_in_if.sink                    in_i,
  sfd_out_if.source                 out_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int EW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int PW = SB + GAIN_W + 1;
  localparam int TW = PW - GAIN_FRAC;
  localparam int SW = TW + 1;

  localparam logic [EW-1:0] MAX_LEN = EW'(MAX_FRAMES);
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  function automatic logic [EW-1:0] clamp_len(logic [LEN_W-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    if (w == '0) w = EW'(1);
    else if (w > MAX_LEN) w = MAX_LEN;
    return w;
  endfunction

  localparam logic [EW-1:0] EFF_RST = clamp_len(LEN_RST);

  // floor(s * g / 32768)
  function automatic logic signed [TW-1:0] mulq(logic signed [SB-1:0] s, gain_t g);
    logic signed [PW-1:0] p;
    p = PW'(s) * PW'($signed({1'b0, g}));
    return p[PW-1:GAIN_FRAC];
  endfunction

  function automatic logic signed [SB-1:0] sat(logic signed [SW-1:0] v);
    if (v > SAT_HI) return SAT_HI[SB-1:0];
    else if (v < SAT_LO) return SAT_LO[SB-1:0];
    else return v[SB-1:0];
  endfunction

  // configuration and pointer state
  logic [EW-1:0] eff_len_q, eff_len_d;
  gain_t         fb_q, dry_q, wet_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW:0]   fill_q, fill_d;
  logic [AW:0]   ptr_inc;
  logic [EW-1:0] new_len;

  // pipeline
  logic                 s1_v_q, s2_v_q, out_v_q;
  logic [AW-1:0]        s1_addr_q, s2_addr_q;
  logic                 s1_live_q;
  logic signed [SB-1:0] s1_x_q [2];
  logic [2*SB-1:0]      rd_q;
  logic signed [SB-1:0] s1_d [2];
  logic signed [SB-1:0] s2_x_q [2];
  logic signed [TW-1:0] s2_pfb_q [2];
  logic signed [TW-1:0] s2_pdry_q [2];
  logic signed [TW-1:0] s2_pwet_q [2];
  logic signed [SB-1:0] stored [2];
  logic signed [SB-1:0] mix [2];
  logic signed [SB-1:0] out_l_q, out_r_q;

  logic [2*SB-1:0] mem_q [MAX_FRAMES];

  logic in_xfer, hazard, out_adv, s2_adv, s1_adv, mem_we;

  assign out_adv = !out_v_q || out_o.ready;
  assign s2_adv  = !s2_v_q || out_adv;
  assign s1_adv  = !s1_v_q || s2_adv;
  // interlock: the entry must not be pending a write-back
  assign hazard  = (s1_v_q && s1_addr_q == ptr_q) || (s2_v_q && s2_addr_q == ptr_q);
  assign in_i.ready = s1_adv && !hazard;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign mem_we     = s2_v_q && out_adv;

  assign out_o.valid     = out_v_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

  assign ptr_inc = {1'b0, ptr_q} + (AW+1)'(1);
  assign new_len = clamp_len(cfg_wdata_i[LEN_W-1:0]);

  always_comb begin
    eff_len_d = eff_len_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    if (in_xfer) begin
      ptr_d = (EW'(ptr_inc) >= eff_len_q) ? '0 : ptr_inc[AW-1:0];
      if ({1'b0, ptr_q} == fill_q) fill_d = fill_q + (AW+1)'(1);
    end
    if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_DELAY_LENGTH) begin
      eff_len_d = new_len;
      if (EW'(ptr_q) >= new_len) ptr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= EFF_RST;
      fb_q      <= FB_RST;
      dry_q     <= DRY_RST;
      wet_q     <= WET_RST;
      ptr_q     <= '0;
      fill_q    <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      eff_len_q <= eff_len_d;
      ptr_q     <= ptr_d;
      fill_q    <= fill_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_DELAY_LENGTH:  ;
          REG_FEEDBACK_GAIN: fb_q  <= cfg_wdata_i[GAIN_W-1:0];
          REG_DRY_GAIN:      dry_q <= cfg_wdata_i[GAIN_W-1:0];
          REG_WET_GAIN:      wet_q <= cfg_wdata_i[GAIN_W-1:0];
        endcase
      end
      if (s1_adv) s1_v_q <= in_xfer;
      if (s2_adv) s2_v_q <= s1_v_q;
      if (out_adv) out_v_q <= s2_v_q;
    end
  end

  // entries at or above the fill count were never written and read as zero
  always_comb begin
    s1_d[0] = s1_live_q ? $signed(rd_q[SB-1:0]) : '0;
    s1_d[1] = s1_live_q ? $signed(rd_q[2*SB-1:SB]) : '0;
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      stored[c] = sat(SW'(s2_x_q[c]) + SW'(s2_pfb_q[c]));
      mix[c]    = sat(SW'(s2_pdry_q[c]) + SW'(s2_pwet_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q      <= mem_q[ptr_q];
      s1_addr_q <= ptr_q;
      s1_live_q <= {1'b0, ptr_q} < fill_q;
      s1_x_q[0] <= in_i.left_in;
      s1_x_q[1] <= in_i.right_in;
    end
    if (s1_v_q && s2_adv) begin
      s2_addr_q <= s1_addr_q;
      for (int c = 0; c < 2; c++) begin
        s2_x_q[c]    <= s1_x_q[c];
        s2_pfb_q[c]  <= mulq(s1_d[c], fb_q);
        s2_pdry_q[c] <= mulq(s1_x_q[c], dry_q);
        s2_pwet_q[c] <= mulq(s1_d[c], wet_q);
      end
    end
    if (mem_we) begin
      mem_q[s2_addr_q] <= {stored[1], stored[0]};
      out_l_q          <= mix[0];
      out_r_q          <= mix[1];
    end
  end

`ifndef SYNTHESIS
  a_ptr_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(ptr_q) < eff_len_q) else $error("write pointer beyond delay length");

  a_ptr_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} <= fill_q) else $error("write pointer ahead of fill count");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q |-> s1_addr_q != s2_addr_q)
    else $error("two frames in flight on one delay entry");
`endif

endmodule

`default_nettype wire

[dv/sfd_checker.sv]
// sfd_checker: watches the config port and both frame channels of the stereo echo core,
// predicts each output frame from its own copy of the delay memory and compares.
// Depends on sfd_pkg, sfd_in_if and sfd_out_if.

module sfd_checker
  import sfd_pkg::*;
#(
  parameter int MAX_FRAMES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  sfd_in_if                    in_ch_i,
  sfd_out_if                   out_ch_i,
  output int                   mismatch_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;

  frame_t      echo_mem [MAX_FRAMES];
  frame_t      mix_due [$];
  len_t        len_q;
  gain_t       fb_q;
  gain_t       dry_q;
  gain_t       wet_q;
  int unsigned wptr;
  int          errors;

  function automatic int unsigned span(len_t len);
    if (len == 0) return 1;
    if (len > MAX_FRAMES) return MAX_FRAMES;
    return len;
  endfunction

  // product floored to the integer part of the q1.15 result
  function automatic logic signed [47:0] scale_q15(logic signed [23:0] s, gain_t g);
    logic signed [47:0] prod;
    prod = s * $signed({1'b0, g});
    return prod >>> GAIN_FRAC;
  endfunction

  function automatic logic signed [23:0] clamp24(logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7fffff;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic frame_t echo_step(frame_t x);
    frame_t d;
    frame_t stored;
    frame_t mix;
    d = echo_mem[wptr];
    stored.left  = clamp24($signed(x.left) + scale_q15(d.left, fb_q));
    stored.right = clamp24($signed(x.right) + scale_q15(d.right, fb_q));
    mix.left     = clamp24(scale_q15(x.left, dry_q) + scale_q15(d.left, wet_q));
    mix.right    = clamp24(scale_q15(x.right, dry_q) + scale_q15(d.right, wet_q));
    echo_mem[wptr] = stored;
    wptr++;
    if (wptr >= span(len_q)) wptr = 0;
    return mix;
  endfunction

  function automatic void flag(string what, logic [23:0] want, logic [23:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t mismatch on %s: expected %0d got %0d", $realtime, what,
               $signed(want), $signed(got));
    end
  endfunction

  // inputs only move at the rising edge, so the falling edge sees what the next edge takes
  always @(negedge clk_i) begin
    frame_t got;
    frame_t want;
    frame_t x;
    if (!rst_ni) begin
      foreach (echo_mem[k]) echo_mem[k] = '0;
      mix_due.delete();
      len_q  = LEN_RST;
      fb_q   = FB_RST;
      dry_q  = DRY_RST;
      wet_q  = WET_RST;
      wptr   = 0;
      errors = 0;
    end else begin
      if (out_ch_i.valid && out_ch_i.ready) begin
        got.left  = out_ch_i.left_out;
        got.right = out_ch_i.right_out;
        if (mix_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t output frame with none expected: got %0d %0d", $realtime,
                     $signed(got.left), $signed(got.right));
          end
        end else begin
          want = mix_due.pop_front();
          if (got.left !== want.left) flag("left_out", want.left, got.left);
          if (got.right !== want.right) flag("right_out", want.right, got.right);
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_DELAY_LENGTH: begin
            len_q = cfg_wdata_i[LEN_W-1:0];
            if (wptr >= span(len_q)) wptr = 0;
          end
          REG_FEEDBACK_GAIN: fb_q  = cfg_wdata_i[GAIN_W-1:0];
          REG_DRY_GAIN:      dry_q = cfg_wdata_i[GAIN_W-1:0];
          REG_WET_GAIN:      wet_q = cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch_i.valid && in_ch_i.ready) begin
        x.left  = in_ch_i.left_in;
        x.right = in_ch_i.right_in;
        mix_due.push_back(echo_step(x));
      end
    end
    mismatch_o = errors;
    pending_o  = mix_due.size();
  end

endmodule

[dv/testbench.sv]
// testbench: drives stereo frames and delay settings into stereo_feedback_delay_core,
// with random idling on both channels; sfd_checker predicts and compares the output.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_checker and the core.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int TOTAL_FRAMES = 1250;
  localparam int FINAL_RUN    = 150;
  localparam int STALL_LIMIT  = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_reg_e             cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   pending;
  int                   sent;
  bit                   calm;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stereo_feedback_delay_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  sfd_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (in_ch),
    .out_ch_i    (out_ch),
    .mismatch_o  (mismatches),
    .pending_o   (pending)
  );

  function automatic logic [23:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return {{16{r[7]}}, r[7:0]};
      3: return {{4{r[19]}}, r[19:0]};
      default: return r[23:0];
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd32768;
      2: return 16'hffff;
      3: return 16'($urandom_range(30000, 34000));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short lines so that echoes come back and pile up through the feedback
  function automatic len_t pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'd1;
      2: return 17'd2;
      3: return 17'd3;
      7: return 17'($urandom_range(17, 300));
      8: return 17'd65536;
      9: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(4, 16));
    endcase
  endfunction

  task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_frame(pick_sample(), pick_sample());
  endtask

  // settings change only with the pipeline empty
  task automatic apply_setting(input len_t len, input gain_t fb, input gain_t dry,
                               input gain_t wet);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DELAY_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    // bit 16 is outside the gain registers and must be dropped
    cfg_idx   <= REG_FEEDBACK_GAIN;
    cfg_wdata <= {$urandom_range(0, 1) != 0, fb};
    @(posedge clk);
    cfg_idx   <= REG_DRY_GAIN;
    cfg_wdata <= {$urandom_range(0, 1) != 0, dry};
    @(posedge clk);
    cfg_idx   <= REG_WET_GAIN;
    cfg_wdata <= {$urandom_range(0, 1) != 0, wet};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    sent = 0;
    calm = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_DELAY_LENGTH;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full-length line, unity dry, extremes pass straight through
    send_frame(24'h7fffff, 24'h800000);
    send_frame(24'h800000, 24'h7fffff);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'hffffff, 24'h000001);

    // zero length acts as one frame; gains near 2.0 drive both sums into saturation
    apply_setting(17'd0, 16'hffff, 16'hffff, 16'hffff);
    repeat (3) send_frame(24'h7fffff, 24'h7fffff);
    repeat (3) send_frame(24'h800000, 24'h800000);

    apply_setting(17'd2, 16'd32768, 16'd0, 16'd32768);
    send_frame(24'h7fffff, 24'h800000);
    send_random(4);
    send_frame(24'h800000, 24'h7fffff);

    // length beyond capacity clamps to the full memory, pointer is kept
    apply_setting(17'h1ffff, 16'd0, 16'd32768, 16'd0);
    send_random(4);

    // shorter than the current pointer: pointer returns to the start
    apply_setting(17'd3, 16'd24576, 16'd16384, 16'd32768);
    send_random(5);

    while (sent < TOTAL_FRAMES - FINAL_RUN) begin
      apply_setting(pick_length(), pick_gain(), pick_gain(), pick_gain());
      calm = ($urandom_range(0, 4) == 0);
      send_random($urandom_range(40, 120));
    end

    calm = 1'b1;
    apply_setting(17'($urandom_range(3, 9)), pick_gain(), pick_gain(), pick_gain());
    send_random(FINAL_RUN);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sfd_pkg.sv
rtl/core/sfd_in_if.sv
rtl/core/sfd_out_if.sv
rtl/core/stereo_feedback_delay_core.sv
dv/sfd_checker.sv
dv/testbench.sv
